### rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants for the great circle distance pipeline
// CORDIC table, fixed-point constants and stage latencies.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int STEPS = 30;

  // Arctangent of 2^-i in phase units (2^32 units per turn), rounded.
  localparam logic [29:0] ATAN_TAB [STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
  localparam logic [30:0] Q_ONE = 31'd1073741824;
  localparam logic [33:0] PI_Q32 = 34'd13493037705;
  localparam logic [25:0] RADIUS_RESET = 26'd6371000;
  localparam logic [27:0] DIST_MAX = 28'hFFFFFFF;

  localparam int ROT_LAT = STEPS + 2;
  localparam int SQRT_STEPS = 31;
  localparam int SQRT_LAT = SQRT_STEPS + 1;

endpackage

### rtl/gcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_if: valid/ready channels of the great circle distance block
// Input word with two points, result word with one distance.
// ----------------------------------------------------------------------------
interface gcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_latitude;
  logic signed [31:0] first_longitude;
  logic signed [31:0] second_latitude;
  logic signed [31:0] second_longitude;
  modport source(output valid, first_latitude, first_longitude, second_latitude,
                 second_longitude, input ready);
  modport sink(input valid, first_latitude, first_longitude, second_latitude,
               second_longitude, output ready);
endinterface

interface gcd_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] distance;
  modport source(output valid, distance, input ready);
  modport sink(input valid, distance, output ready);
endinterface

### rtl/great_circle_distance_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_top: haversine distance between two points
// Fully pipelined fixed-point datapath, one pair per clock unless stalled.
// ----------------------------------------------------------------------------
// Each input word on in_chan carries two points as signed binary angles
// (2^32 units per turn). Each result word on out_chan carries the great
// circle distance in radius units, rounded to nearest and saturated.
// The radius comes from cfg_wdata, written when cfg_we is high; it resets
// to 6371000 and must only be changed while no word is in flight.
// From input acceptance to output valid a word passes one input stage, a
// 32-stage rotation CORDIC, two product stages, a 32-stage square root,
// a 31-stage vectoring CORDIC, and four multiplier stages split into
// partial products. Throughput is one word per cycle unless stalled.
// The whole pipeline moves on one enable that is high when the final
// output register is empty or being taken, so in_chan.ready follows
// out_chan.ready whenever a result waits; a stall holds every stage, and
// nothing is lost or repeated. Synchronous active-low reset clears the
// valid bits and restores the radius; datapath registers are not reset.
// ----------------------------------------------------------------------------
module great_circle_distance_top #(
  parameter int ANGLE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  gcd_in_if.sink       in_chan,
  gcd_out_if.source    out_chan,
  input  logic         cfg_we,
  input  logic [25:0]  cfg_wdata
);

  localparam int N = gcd_pkg::STEPS;
  localparam int LAT = 1 + gcd_pkg::ROT_LAT + 2 + gcd_pkg::SQRT_LAT + N + 1 + 4;
  // Only the top ANGLE_WIDTH bits of each angle take part.
  localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_WIDTH)) - 32'd1);

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [25:0]    radius_r;

  // The pipeline advances unless a finished result is held at the output.
  assign en = !vld_r[LAT-1] || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      radius_r <= gcd_pkg::RADIUS_RESET;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_chan.valid};
      if (cfg_we) radius_r <= cfg_wdata;
    end
  end

  // Input stage: clip the angles and form the half differences.
  logic [31:0] lat1_c, lon1_c, lat2_c, lon2_c, dlat, dlon;
  logic [31:0] hlat_r, hlon_r, lat1_r, lat2_r;

  assign lat1_c = $unsigned(in_chan.first_latitude) & ANGLE_MASK;
  assign lon1_c = $unsigned(in_chan.first_longitude) & ANGLE_MASK;
  assign lat2_c = $unsigned(in_chan.second_latitude) & ANGLE_MASK;
  assign lon2_c = $unsigned(in_chan.second_longitude) & ANGLE_MASK;
  assign dlat = lat2_c - lat1_c;
  assign dlon = lon2_c - lon1_c;

  always_ff @(posedge clk) begin
    if (en) begin
      hlat_r <= dlat >> 1;
      hlon_r <= dlon >> 1;
      lat1_r <= lat1_c;
      lat2_r <= lat2_c;
    end
  end

  // Four rotation CORDICs run side by side.
  logic signed [33:0] s_lat, s_lon, c_1, c_2;

  gcd_rot u_rot_hlat (.clk(clk), .en(en), .phase_i(hlat_r), .sin_o(s_lat), .cos_o());
  gcd_rot u_rot_hlon (.clk(clk), .en(en), .phase_i(hlon_r), .sin_o(s_lon), .cos_o());
  gcd_rot u_rot_lat1 (.clk(clk), .en(en), .phase_i(lat1_r), .sin_o(), .cos_o(c_1));
  gcd_rot u_rot_lat2 (.clk(clk), .en(en), .phase_i(lat2_r), .sin_o(), .cos_o(c_2));

  // First product stage: the three independent Q2.30 products.
  logic signed [31:0] sl_n, so_n, c1_n, c2_n;
  logic signed [63:0] m_sl, m_so, m_cc;
  logic signed [33:0] sl2_r, so2_r, cc_r;

  assign sl_n = 32'(s_lat);
  assign so_n = 32'(s_lon);
  assign c1_n = 32'(c_1);
  assign c2_n = 32'(c_2);
  assign m_sl = sl_n * sl_n;
  assign m_so = so_n * so_n;
  assign m_cc = c1_n * c2_n;

  always_ff @(posedge clk) begin
    if (en) begin
      sl2_r <= 34'(m_sl >>> 30);
      so2_r <= 34'(m_so >>> 30);
      cc_r <= 34'(m_cc >>> 30);
    end
  end

  // Second product stage: the longitude term, the sum and the clamp of a.
  logic signed [31:0] cc_n, so2_n;
  logic signed [63:0] m_t;
  logic signed [34:0] a_sum;
  logic [30:0]        a_r;

  assign cc_n = 32'(cc_r);
  assign so2_n = 32'(so2_r);
  assign m_t = cc_n * so2_n;
  assign a_sum = 35'(sl2_r) + 35'(m_t >>> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      if (a_sum < 0) a_r <= '0;
      else if (a_sum > $signed({4'b0000, gcd_pkg::Q_ONE})) a_r <= gcd_pkg::Q_ONE;
      else a_r <= 31'(a_sum);
    end
  end

  // Square roots of a and of one minus a, both in unsigned Q1.30.
  logic [30:0] sy, sx;
  logic [30:0] a_c;

  assign a_c = gcd_pkg::Q_ONE - a_r;

  gcd_isqrt u_sqrt_y (.clk(clk), .en(en), .v_i({a_r, 30'd0}), .root_o(sy));
  gcd_isqrt u_sqrt_x (.clk(clk), .en(en), .v_i({a_c, 30'd0}), .root_o(sx));

  // Vectoring CORDIC: accumulates the angle of (sx, sy) while driving y to 0.
  logic signed [33:0] vx_r [0:N-1];
  logic signed [33:0] vy_r [0:N-1];
  logic signed [32:0] vz_r [0:N-1];
  logic [31:0]        z_r;

  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [33:0] x_p, y_p;
    logic signed [32:0] z_p;
    if (i == 0) begin : g_first
      assign x_p = $signed({3'b000, sx});
      assign y_p = $signed({3'b000, sy});
      assign z_p = '0;
    end else begin : g_rest
      assign x_p = vx_r[i-1];
      assign y_p = vy_r[i-1];
      assign z_p = vz_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_p >= 0) begin
          vx_r[i] <= x_p + (y_p >>> i);
          vy_r[i] <= y_p - (x_p >>> i);
          vz_r[i] <= z_p + $signed({3'b000, gcd_pkg::ATAN_TAB[i]});
        end else begin
          vx_r[i] <= x_p - (y_p >>> i);
          vy_r[i] <= y_p + (x_p >>> i);
          vz_r[i] <= z_p - $signed({3'b000, gcd_pkg::ATAN_TAB[i]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) z_r <= (vz_r[N-1] < 0) ? 32'd0 : 32'(vz_r[N-1]);
  end

  // Central angle in Q32 radians, from two 32x17 partial products.
  logic [48:0] ph_r, pl_r;
  logic [65:0] cq_sum;
  logic [35:0] cq_r;

  assign cq_sum = ({17'd0, ph_r} << 17) + {17'd0, pl_r} + (66'd1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= z_r * gcd_pkg::PI_Q32[33:17];
      pl_r <= z_r * gcd_pkg::PI_Q32[16:0];
      cq_r <= 36'(cq_sum >> 30);
    end
  end

  // Scale by the radius, again split into two partial products.
  logic [44:0] rh_r;
  logic [42:0] rl_r;
  logic [63:0] d_sum, d_full;
  logic [27:0] dist_r;

  assign d_sum = ({19'd0, rh_r} << 17) + {21'd0, rl_r} + (64'd1 << 31);
  assign d_full = d_sum >> 32;

  always_ff @(posedge clk) begin
    if (en) begin
      rh_r <= radius_r * cq_r[35:17];
      rl_r <= radius_r * cq_r[16:0];
      dist_r <= (d_full > {36'd0, gcd_pkg::DIST_MAX}) ? gcd_pkg::DIST_MAX : 28'(d_full);
    end
  end

  assign out_chan.valid = vld_r[LAT-1];
  assign out_chan.distance = dist_r;

endmodule

### rtl/gcd_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_rot: pipelined rotation CORDIC
// Sine and cosine of a 32-bit phase in Q2.30, one step per stage.
// ----------------------------------------------------------------------------
module gcd_rot (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase_i,
  output logic signed [33:0] sin_o,
  output logic signed [33:0] cos_o
);

  localparam int N = gcd_pkg::STEPS;

  logic signed [33:0] x_r [0:N];
  logic signed [33:0] y_r [0:N];
  logic signed [32:0] p_r [0:N];
  logic               flip_r [0:N];
  logic signed [33:0] sin_r, cos_r;

  logic signed [32:0] p_raw, p_nxt;
  logic               flip_nxt;

  // Fold the phase into the right half plane and negate the results there.
  always_comb begin
    p_raw = $signed({phase_i[31], phase_i});
    p_nxt = p_raw;
    flip_nxt = 1'b0;
    if (p_raw > 33'sd1073741824) begin
      p_nxt = p_raw - 33'sd2147483648;
      flip_nxt = 1'b1;
    end else if (p_raw < -33'sd1073741824) begin
      p_nxt = p_raw + 33'sd2147483648;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= gcd_pkg::GAIN_INV;
      y_r[0] <= '0;
      p_r[0] <= p_nxt;
      flip_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (p_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          p_r[i+1] <= p_r[i] - $signed({3'b000, gcd_pkg::ATAN_TAB[i]});
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          p_r[i+1] <= p_r[i] + $signed({3'b000, gcd_pkg::ATAN_TAB[i]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= flip_r[N] ? -y_r[N] : y_r[N];
      cos_r <= flip_r[N] ? -x_r[N] : x_r[N];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

### rtl/gcd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_isqrt: pipelined integer square root
// Floor square root of a 61-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module gcd_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] v_i,
  output logic [30:0] root_o
);

  localparam int N = gcd_pkg::SQRT_STEPS;

  logic [61:0] rem_r  [0:N];
  logic [30:0] root_r [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, v_i};
      root_r[0] <= '0;
    end
  end

  // Stage j decides bit k; the remainder holds v minus the root squared.
  for (genvar j = 0; j < N; j++) begin : g_bit
    localparam int K = N - 1 - j;
    logic [61:0] trial;
    assign trial = ({31'd0, root_r[j]} << (K + 1)) + (62'd1 << (2 * K));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[j] >= trial) begin
          rem_r[j+1] <= rem_r[j] - trial;
          root_r[j+1] <= root_r[j] | (31'd1 << K);
        end else begin
          rem_r[j+1] <= rem_r[j];
          root_r[j+1] <= root_r[j];
        end
      end
    end
  end

  assign root_o = root_r[N];

endmodule
